// File: hdl/vra_pkg.sv
package vra_pkg;

    // cordic length and pipeline depth
    localparam int CORDIC_STEPS = 24;
    localparam int LANES = 3;
    localparam int LANE_DEPTH = 12;
    localparam int PIPE_DEPTH = CORDIC_STEPS + 2 + LANE_DEPTH;

    // operand split of the pipelined multiplier
    localparam int AW = 48;
    localparam int BW = 33;
    localparam int PW = AW + BW;
    localparam int LO_W = 24;
    localparam int ZW = 36;

    typedef logic signed [31:0] vec_t;
    typedef logic signed [AW-1:0] opa_t;
    typedef logic signed [BW-1:0] trig_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [ZW-1:0] zang_t;
    typedef logic signed [41:0] kvp_t;
    typedef logic signed [42:0] cr_t;
    typedef logic signed [43:0] dot_t;
    typedef logic signed [57:0] sum_t;
    typedef logic signed [42:0] res_t;

    localparam zang_t HALF_PI = zang_t'(64'sd1686629713);
    localparam zang_t PI = zang_t'(64'sd3373259426);
    localparam zang_t CORDIC_GAIN = zang_t'(64'sd652032874);
    localparam trig_t ONE_Q30 = trig_t'(64'sd1073741824);

    // arctangent of 2^-i in q.30
    function automatic zang_t atan_q30(int i);
        zang_t r;
        unique case (i)
            0: r = zang_t'(843314856);
            1: r = zang_t'(497837829);
            2: r = zang_t'(263043836);
            3: r = zang_t'(133525158);
            4: r = zang_t'(67021686);
            5: r = zang_t'(33543515);
            6: r = zang_t'(16775850);
            7: r = zang_t'(8388437);
            8: r = zang_t'(4194282);
            9: r = zang_t'(2097149);
            10: r = zang_t'(1048575);
            11: r = zang_t'(524287);
            12: r = zang_t'(262143);
            13: r = zang_t'(131071);
            14: r = zang_t'(65535);
            15: r = zang_t'(32767);
            16: r = zang_t'(16383);
            17: r = zang_t'(8191);
            18: r = zang_t'(4095);
            19: r = zang_t'(2047);
            20: r = zang_t'(1023);
            21: r = zang_t'(511);
            22: r = zang_t'(255);
            23: r = zang_t'(127);
            24: r = zang_t'(63);
            25: r = zang_t'(31);
            26: r = zang_t'(15);
            27: r = zang_t'(7);
            28: r = zang_t'(3);
            29: r = zang_t'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // round to nearest, ties up, then drop sh bits
    function automatic prod_t rnd(prod_t p, int sh);
        prod_t bias;
        bias = '0;
        bias[sh-1] = 1'b1;
        return (p + bias) >>> sh;
    endfunction

endpackage

// File: hdl/vector_rotate_about_axis_unit.sv
// throughput: one item per cycle while the skid register is free; every cordic step is its own stage
// the three component lanes and the dot product merge run fully pipelined
// a skid register lets an item enter while a result waits on out_stall
// reset clears only the valid bits; payload registers are not reset
module vector_rotate_about_axis_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  vra_pkg::vec_t        vec_x,
    input  vra_pkg::vec_t        vec_y,
    input  vra_pkg::vec_t        vec_z,
    input  vra_pkg::vec_t        axis_x,
    input  vra_pkg::vec_t        axis_y,
    input  vra_pkg::vec_t        axis_z,
    input  vra_pkg::vec_t        turn_angle,
    output logic                 out_valid,
    input  logic                 out_stall,
    output vra_pkg::vec_t        rot_x,
    output vra_pkg::vec_t        rot_y,
    output vra_pkg::vec_t        rot_z,
    output logic                 clipped
);

    localparam int N = vra_pkg::CORDIC_STEPS;

    logic           adv;
    logic           push;
    logic           valid_reg [vra_pkg::PIPE_DEPTH];
    vra_pkg::vec_t  v0_reg [vra_pkg::LANES];
    vra_pkg::vec_t  k0_reg [vra_pkg::LANES];
    vra_pkg::zang_t z0_reg;
    logic           flip0_reg;
    vra_pkg::zang_t z2;
    vra_pkg::vec_t  vd_reg [N+1][vra_pkg::LANES];
    vra_pkg::vec_t  kd_reg [N+1][vra_pkg::LANES];
    vra_pkg::trig_t c_cor;
    vra_pkg::trig_t s_cor;
    vra_pkg::trig_t omc_cor;
    vra_pkg::trig_t cd_reg [7];
    vra_pkg::trig_t sd_reg [7];
    vra_pkg::trig_t omd_reg [4];
    vra_pkg::kvp_t  lane_p [vra_pkg::LANES];
    vra_pkg::vec_t  lane_rot [vra_pkg::LANES];
    logic           lane_clip [vra_pkg::LANES];
    vra_pkg::dot_t  dot_reg;
    vra_pkg::prod_t pf;
    vra_pkg::opa_t  f_reg;
    logic           out_valid_reg;
    vra_pkg::vec_t  out_rot_reg [vra_pkg::LANES];
    logic           out_clip_reg;
    logic           skid_valid_reg;
    vra_pkg::vec_t  skid_rot_reg [vra_pkg::LANES];
    logic           skid_clip_reg;

    // the pipeline moves whenever the skid register is free
    assign adv = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign push = adv && valid_reg[vra_pkg::PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vra_pkg::PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < vra_pkg::PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // fold the doubled angle into the cordic range
    assign z2 = vra_pkg::zang_t'(turn_angle) <<< 1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v0_reg[0] <= vec_x;
            v0_reg[1] <= vec_y;
            v0_reg[2] <= vec_z;
            k0_reg[0] <= axis_x;
            k0_reg[1] <= axis_y;
            k0_reg[2] <= axis_z;
            if (z2 > vra_pkg::HALF_PI)
            begin
                z0_reg <= z2 - vra_pkg::PI;
                flip0_reg <= 1'b1;
            end
            else if (z2 < -vra_pkg::HALF_PI)
            begin
                z0_reg <= z2 + vra_pkg::PI;
                flip0_reg <= 1'b1;
            end
            else
            begin
                z0_reg <= z2;
                flip0_reg <= 1'b0;
            end
        end
    end

    vra_cordic u_cordic
    (
        .clk(clk),
        .en(adv),
        .z_in(z0_reg),
        .flip_in(flip0_reg),
        .c(c_cor),
        .s(s_cor),
        .omc(omc_cor)
    );

    // vector and axis wait for sine and cosine
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < vra_pkg::LANES; l++)
            begin
                vd_reg[0][l] <= v0_reg[l];
                kd_reg[0][l] <= k0_reg[l];
                for (int i = 1; i <= N; i++)
                begin
                    vd_reg[i][l] <= vd_reg[i-1][l];
                    kd_reg[i][l] <= kd_reg[i-1][l];
                end
            end
        end
    end

    // trig values wait for the merge stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cd_reg[0] <= c_cor;
            sd_reg[0] <= s_cor;
            for (int i = 1; i < 7; i++)
            begin
                cd_reg[i] <= cd_reg[i-1];
                sd_reg[i] <= sd_reg[i-1];
            end
            omd_reg[0] <= omc_cor;
            for (int i = 1; i < 4; i++)
            begin
                omd_reg[i] <= omd_reg[i-1];
            end
        end
    end

    // one lane per component
    for (genvar l = 0; l < vra_pkg::LANES; l++)
    begin : g_lane
        vra_lane u_lane
        (
            .clk(clk),
            .en(adv),
            .v_self(vd_reg[N][l]),
            .k_self(kd_reg[N][l]),
            .v_a(vd_reg[N][(l+1)%vra_pkg::LANES]),
            .k_a(kd_reg[N][(l+1)%vra_pkg::LANES]),
            .v_b(vd_reg[N][(l+2)%vra_pkg::LANES]),
            .k_b(kd_reg[N][(l+2)%vra_pkg::LANES]),
            .c(cd_reg[6]),
            .s(sd_reg[6]),
            .f(f_reg),
            .p(lane_p[l]),
            .rot(lane_rot[l]),
            .clip(lane_clip[l])
        );
    end

    // merge: dot product and its scale by one minus cosine
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dot_reg <= vra_pkg::dot_t'(lane_p[0]) + vra_pkg::dot_t'(lane_p[1])
                     + vra_pkg::dot_t'(lane_p[2]);
            f_reg <= vra_pkg::opa_t'(vra_pkg::rnd(pf, 30));
        end
    end

    vra_mul u_mul_f
    (
        .clk(clk),
        .en(adv),
        .a(vra_pkg::opa_t'(dot_reg)),
        .b(omd_reg[3]),
        .p(pf)
    );

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_rot_reg <= skid_rot_reg;
                out_clip_reg <= skid_clip_reg;
            end
            else
            begin
                out_rot_reg <= lane_rot;
                out_clip_reg <= lane_clip[0] | lane_clip[1] | lane_clip[2];
            end
        end
        else if (push)
        begin
            skid_rot_reg <= lane_rot;
            skid_clip_reg <= lane_clip[0] | lane_clip[1] | lane_clip[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign rot_x = out_rot_reg[0];
    assign rot_y = out_rot_reg[1];
    assign rot_z = out_rot_reg[2];
    assign clipped = out_clip_reg;

`ifndef ASSERT_OFF
    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid item not moved to output");

    a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && !skid_valid_reg && valid_reg[vra_pkg::PIPE_DEPTH-1])
        |=> skid_valid_reg)
        else $error("finished item lost while output stalled");
`endif

endmodule

// File: hdl/vra_mul.sv
module vra_mul
(
    input  logic                 clk,
    input  logic                 en,
    input  vra_pkg::opa_t        a,
    input  vra_pkg::trig_t       b,
    output vra_pkg::prod_t       p
);

    logic signed [vra_pkg::LO_W+vra_pkg::BW:0] lo_reg;
    logic signed [vra_pkg::AW-vra_pkg::LO_W+vra_pkg::BW-1:0] hi_reg;
    vra_pkg::prod_t p_reg;

    // partial products of low and high halves of a
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= $signed({1'b0, a[vra_pkg::LO_W-1:0]}) * b;
            hi_reg <= $signed(a[vra_pkg::AW-1:vra_pkg::LO_W]) * b;
        end
    end

    // recombine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (vra_pkg::prod_t'(hi_reg) <<< vra_pkg::LO_W) + vra_pkg::prod_t'(lo_reg);
        end
    end

    assign p = p_reg;

endmodule

// File: hdl/vra_cordic.sv
module vra_cordic
(
    input  logic                 clk,
    input  logic                 en,
    input  vra_pkg::zang_t       z_in,
    input  logic                 flip_in,
    output vra_pkg::trig_t       c,
    output vra_pkg::trig_t       s,
    output vra_pkg::trig_t       omc
);

    vra_pkg::zang_t x_reg [vra_pkg::CORDIC_STEPS];
    vra_pkg::zang_t y_reg [vra_pkg::CORDIC_STEPS];
    vra_pkg::zang_t z_reg [vra_pkg::CORDIC_STEPS];
    logic           flip_reg [vra_pkg::CORDIC_STEPS];
    vra_pkg::trig_t c_reg;
    vra_pkg::trig_t s_reg;
    vra_pkg::trig_t omc_reg;
    vra_pkg::trig_t c_next;

    // one micro-rotation per stage
    for (genvar j = 0; j < vra_pkg::CORDIC_STEPS; j++)
    begin : g_stage
        vra_pkg::zang_t xi;
        vra_pkg::zang_t yi;
        vra_pkg::zang_t zi;
        logic           fi;
        if (j == 0)
        begin : g_first
            assign xi = vra_pkg::CORDIC_GAIN;
            assign yi = '0;
            assign zi = z_in;
            assign fi = flip_in;
        end
        else
        begin : g_rest
            assign xi = x_reg[j-1];
            assign yi = y_reg[j-1];
            assign zi = z_reg[j-1];
            assign fi = flip_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[j] <= fi;
                if (zi >= 0)
                begin
                    x_reg[j] <= xi - (yi >>> j);
                    y_reg[j] <= yi + (xi >>> j);
                    z_reg[j] <= zi - vra_pkg::atan_q30(j);
                end
                else
                begin
                    x_reg[j] <= xi + (yi >>> j);
                    y_reg[j] <= yi - (xi >>> j);
                    z_reg[j] <= zi + vra_pkg::atan_q30(j);
                end
            end
        end
    end

    // undo the half-turn fold
    assign c_next = flip_reg[vra_pkg::CORDIC_STEPS-1]
                  ? vra_pkg::trig_t'(-x_reg[vra_pkg::CORDIC_STEPS-1])
                  : vra_pkg::trig_t'(x_reg[vra_pkg::CORDIC_STEPS-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
            omc_reg <= vra_pkg::ONE_Q30 - c_next;
            s_reg <= flip_reg[vra_pkg::CORDIC_STEPS-1]
                   ? vra_pkg::trig_t'(-y_reg[vra_pkg::CORDIC_STEPS-1])
                   : vra_pkg::trig_t'(y_reg[vra_pkg::CORDIC_STEPS-1]);
        end
    end

    assign c = c_reg;
    assign s = s_reg;
    assign omc = omc_reg;

endmodule

// File: hdl/vra_lane.sv
module vra_lane
(
    input  logic                 clk,
    input  logic                 en,
    input  vra_pkg::vec_t        v_self,
    input  vra_pkg::vec_t        k_self,
    input  vra_pkg::vec_t        v_a,
    input  vra_pkg::vec_t        k_a,
    input  vra_pkg::vec_t        v_b,
    input  vra_pkg::vec_t        k_b,
    input  vra_pkg::trig_t       c,
    input  vra_pkg::trig_t       s,
    input  vra_pkg::opa_t        f,
    output vra_pkg::kvp_t        p,
    output vra_pkg::vec_t        rot,
    output logic                 clip
);

    vra_pkg::prod_t pcb;
    vra_pkg::prod_t pab;
    vra_pkg::prod_t pss;
    vra_pkg::prod_t pvc;
    vra_pkg::prod_t pcs;
    vra_pkg::prod_t pfk;
    vra_pkg::cr_t   cr_reg;
    vra_pkg::kvp_t  p_reg;
    vra_pkg::vec_t  vd_reg [7];
    vra_pkg::vec_t  kd_reg [7];
    vra_pkg::cr_t   crd_reg [4];
    vra_pkg::sum_t  t1_reg;
    vra_pkg::sum_t  t2_reg;
    vra_pkg::sum_t  t3_reg;
    vra_pkg::sum_t  sum_reg;
    vra_pkg::res_t  r;
    vra_pkg::vec_t  rot_reg;
    logic           clip_reg;

    // cross product terms and dot product term
    vra_mul u_mul_cb (.clk(clk), .en(en), .a(vra_pkg::opa_t'(v_b)),
                      .b(vra_pkg::trig_t'(k_a)), .p(pcb));
    vra_mul u_mul_ab (.clk(clk), .en(en), .a(vra_pkg::opa_t'(v_a)),
                      .b(vra_pkg::trig_t'(k_b)), .p(pab));
    vra_mul u_mul_ss (.clk(clk), .en(en), .a(vra_pkg::opa_t'(v_self)),
                      .b(vra_pkg::trig_t'(k_self)), .p(pss));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg <= vra_pkg::cr_t'(vra_pkg::rnd(pcb, 22))
                    - vra_pkg::cr_t'(vra_pkg::rnd(pab, 22));
            p_reg <= vra_pkg::kvp_t'(vra_pkg::rnd(pss, 22));
        end
    end

    // hold operands until the scale factor is back
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vd_reg[0] <= v_self;
            kd_reg[0] <= k_self;
            for (int i = 1; i < 7; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
                kd_reg[i] <= kd_reg[i-1];
            end
            crd_reg[0] <= cr_reg;
            for (int i = 1; i < 4; i++)
            begin
                crd_reg[i] <= crd_reg[i-1];
            end
        end
    end

    // the three rodrigues terms
    vra_mul u_mul_vc (.clk(clk), .en(en), .a(vra_pkg::opa_t'(vd_reg[6])),
                      .b(c), .p(pvc));
    vra_mul u_mul_cs (.clk(clk), .en(en), .a(vra_pkg::opa_t'(crd_reg[3])),
                      .b(s), .p(pcs));
    vra_mul u_mul_fk (.clk(clk), .en(en), .a(f),
                      .b(vra_pkg::trig_t'(kd_reg[6])), .p(pfk));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= vra_pkg::sum_t'(vra_pkg::rnd(pvc, 16));
            t2_reg <= vra_pkg::sum_t'(vra_pkg::rnd(pcs, 24));
            t3_reg <= vra_pkg::sum_t'(vra_pkg::rnd(pfk, 24));
            sum_reg <= t1_reg + t2_reg + t3_reg;
        end
    end

    // round to q16.16 and saturate
    assign r = vra_pkg::res_t'(vra_pkg::rnd(vra_pkg::prod_t'(sum_reg), 14));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r[42:31] != {12{r[42]}})
            begin
                rot_reg <= r[42] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
                clip_reg <= 1'b1;
            end
            else
            begin
                rot_reg <= r[31:0];
                clip_reg <= 1'b0;
            end
        end
    end

    assign p = p_reg;
    assign rot = rot_reg;
    assign clip = clip_reg;

endmodule
